// ----- hdl/spimbe_pkg.sv -----
// ----------------------------------------------------------------------------
// spimbe_pkg
// shared types and constants of the spi master byte engine
// ----------------------------------------------------------------------------
package spimbe_pkg;

  localparam int HALF_W = 16;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUS_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd2;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SETUP  = 3'd1,
    PH_FIRST  = 3'd2,
    PH_SECOND = 3'd3,
    PH_WAIT   = 3'd4,
    PH_HOLD   = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0]        bus_mode;
    logic              lsb_first;
    logic [HALF_W-1:0] half_period;
  } cfg_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       miso;
  } item_t;

  typedef struct packed {
    logic       sclk;
    logic       mosi;
    logic       cs_n;
    logic       tx_ready;
    logic       rx_valid;
    logic [7:0] rx_byte;
  } result_t;

endpackage

// ----- hdl/spimbe_step.sv -----
// ----------------------------------------------------------------------------
// spimbe_step
// per-tick serial engine: state registers and the next-state logic of one tick
// ----------------------------------------------------------------------------
module spimbe_step #(
  parameter int DIVIDER_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  spimbe_pkg::cfg_t    cfg,
  input  logic               fire,
  input  spimbe_pkg::item_t   item,
  output spimbe_pkg::result_t res
);
  import spimbe_pkg::*;

  localparam int LW = (DIVIDER_WIDTH > HALF_W) ? DIVIDER_WIDTH : HALF_W;

  phase_t                   phase, phase_next;
  logic [DIVIDER_WIDTH-1:0] tick_count, tick_count_next;
  logic [2:0]               bit_index, bit_index_next;
  logic [7:0]               tx_shift, tx_shift_next;
  logic [7:0]               rx_shift, rx_shift_next;
  logic                     final_pending, final_pending_next;
  logic                     clock_level, clock_level_next;
  logic                     data_level, data_level_next;
  logic                     select_level, select_level_next;

  logic          cpol, cpha;
  logic [LW-1:0] div_mask, limit_raw, limit;
  logic [LW:0]   tick_inc;
  logic          done;
  logic          tx_ready, rx_valid;
  logic [7:0]    rx_byte;
  logic          load, start;
  logic [2:0]    sh;

  assign cpol = cfg.bus_mode[1];
  assign cpha = cfg.bus_mode[0];

  // half period masked to the divider width, zero taken as one
  assign div_mask  = LW'({DIVIDER_WIDTH{1'b1}});
  assign limit_raw = LW'(cfg.half_period) & div_mask;
  assign limit     = (limit_raw == '0) ? LW'(1) : limit_raw;
  assign tick_inc  = (LW+1)'(tick_count) + (LW+1)'(1);
  assign done      = (tick_inc >= {1'b0, limit});

  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    tx_shift_next      = tx_shift;
    rx_shift_next      = rx_shift;
    final_pending_next = final_pending;
    clock_level_next   = clock_level;
    data_level_next    = data_level;
    select_level_next  = select_level;
    tx_ready           = 1'b0;
    rx_valid           = 1'b0;
    rx_byte            = '0;
    load               = 1'b0;
    start              = 1'b0;

    unique case (phase)
      PH_SETUP, PH_FIRST, PH_SECOND, PH_HOLD: begin
        tick_count_next = done ? '0 : tick_count_next + DIVIDER_WIDTH'(1);
      end
      default: begin
      end
    endcase

    unique case (phase)
      PH_SETUP: begin
        start = done;
      end
      PH_FIRST: begin
        if (done) begin
          clock_level_next = cpha ? cpol : ~cpol;
          rx_shift_next    = cfg.lsb_first ? {item.miso, rx_shift[7:1]}
                                           : {rx_shift[6:0], item.miso};
          phase_next       = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (done) begin
          if (!cpha) begin
            clock_level_next = cpol;
          end
          if (bit_index == LAST_BIT) begin
            rx_valid       = 1'b1;
            rx_byte        = rx_shift;
            bit_index_next = '0;
            if (final_pending) begin
              phase_next = PH_HOLD;
            end else if (item.tx_valid) begin
              load  = 1'b1;
              start = 1'b1;
            end else begin
              phase_next = PH_WAIT;
            end
          end else begin
            bit_index_next = bit_index + 3'd1;
            start          = 1'b1;
          end
        end
      end
      PH_WAIT: begin
        if (item.tx_valid) begin
          load  = 1'b1;
          start = 1'b1;
        end
      end
      PH_HOLD: begin
        if (done) begin
          select_level_next = 1'b1;
          clock_level_next  = cpol;
          phase_next        = PH_IDLE;
        end
      end
      default: begin
        clock_level_next  = cpol;
        select_level_next = 1'b1;
        phase_next        = PH_IDLE;
        if (item.tx_valid) begin
          load              = 1'b1;
          select_level_next = 1'b0;
          phase_next        = PH_SETUP;
        end
      end
    endcase

    // take the offered byte
    if (load) begin
      tx_ready           = 1'b1;
      tx_shift_next      = item.tx_byte;
      final_pending_next = item.tx_last;
      bit_index_next     = '0;
      tick_count_next    = '0;
    end

    // drive the next bit onto mosi
    sh = cfg.lsb_first ? bit_index_next : (LAST_BIT - bit_index_next);
    if (start) begin
      if (cpha) begin
        clock_level_next = ~cpol;
      end
      data_level_next = tx_shift_next[sh];
      phase_next      = PH_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      tx_shift      <= '0;
      rx_shift      <= '0;
      final_pending <= 1'b0;
      clock_level   <= 1'b0;
      data_level    <= 1'b0;
      select_level  <= 1'b1;
    end else if (fire) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      tx_shift      <= tx_shift_next;
      rx_shift      <= rx_shift_next;
      final_pending <= final_pending_next;
      clock_level   <= clock_level_next;
      data_level    <= data_level_next;
      select_level  <= select_level_next;
    end
  end

  always_comb begin
    res.sclk     = clock_level_next;
    res.mosi     = data_level_next;
    res.cs_n     = select_level_next;
    res.tx_ready = tx_ready;
    res.rx_valid = rx_valid;
    res.rx_byte  = rx_byte;
  end

endmodule

// ----- hdl/spi_master_byte_engine.sv -----
// ----------------------------------------------------------------------------
// spi_master_byte_engine
// spi master, modes 0 to 3, stepped by one request per clock tick
// ----------------------------------------------------------------------------
// Each request is one tick of the serial engine: it carries the sampled miso
// level and optionally a byte to send with its last-of-transaction mark. The
// result of a request gives the sclk, mosi and cs_n levels after that tick,
// whether the offered byte was taken, and a received byte when one completes.
// Chip select falls on the first offered byte, is held one half period before
// the first bit and one half period after the last byte. Each bit spans two
// half periods of half_period ticks (zero counts as one). A request's result
// is computed combinationally and written at the edge that takes the request,
// into the result register or, while the result side stalls, into a skid
// register behind it that absorbs one request; item_stall rises only when both
// are full. The block sustains one request per cycle while item_stall is low.
// Configuration writes take effect at the next request.
// ----------------------------------------------------------------------------
module spi_master_byte_engine #(
  parameter int DIVIDER_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [spimbe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spimbe_pkg::HALF_W-1:0]      cfg_data,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  spimbe_pkg::item_t                  item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output spimbe_pkg::result_t                result
);
  import spimbe_pkg::*;

  cfg_t    cfg;
  result_t step_res;
  result_t skid;
  logic    skid_valid;
  logic    fire;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bus_mode    <= '0;
      cfg.lsb_first   <= 1'b0;
      cfg.half_period <= HALF_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUS_MODE:    cfg.bus_mode    <= cfg_data[1:0];
        CFG_LSB_FIRST:   cfg.lsb_first   <= cfg_data[0];
        CFG_HALF_PERIOD: cfg.half_period <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // request is taken whenever the skid register is free
  assign item_stall = skid_valid;
  assign fire       = item_valid && !item_stall;

  spimbe_step #(
    .DIVIDER_WIDTH(DIVIDER_WIDTH)
  ) u_step (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (fire),
    .item (item),
    .res  (step_res)
  );

  // result register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= fire;
      end
    end else if (fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result <= skid;
      end else if (fire) begin
        result <= step_res;
      end
    end else if (fire) begin
      skid <= step_res;
    end
  end

  // a byte is only reported taken when one was offered
  a_ready_needs_offer: assert property (@(posedge clk) disable iff (rst)
    fire && step_res.tx_ready |-> item.tx_valid)
    else $error("tx_ready without an offered byte");

  // skid entry only exists behind a full result register
  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry with empty result register");

  // request side stalls only after the result side stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(item_stall) |-> $past(result_valid && result_stall))
    else $error("request stall without result stall");

  // received byte is zero unless a byte completes
  a_rx_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.rx_valid |-> result.rx_byte == 8'd0)
    else $error("rx_byte set without rx_valid");

endmodule

// ----- tb/spi_master_byte_engine_test.sv -----
// ----------------------------------------------------------------------------
// spi_master_byte_engine_test
// self-checking bench for the tick-stepped spi master byte engine
// ----------------------------------------------------------------------------
// Each request is one tick of the engine. A behavioral copy of the engine
// runs on every accepted request and queues the sclk, mosi and cs_n levels,
// the take flag and the received byte that the tick must produce. Results are
// popped and compared field by field. A short directed table opens the run.
// Then come phases of constrained-by-hand random transactions, each with its
// own spi mode, bit order, divider and idle/stall profile.
// ----------------------------------------------------------------------------
module spi_master_byte_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  import spimbe_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    item_t   req;
    logic    typed;
    result_t want;
  } dir_row_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic              lsb;
    logic [HALF_W-1:0] half;
    logic [6:0]        idle_pct;
    logic [6:0]        stall_pct;
    logic [11:0]       items;
  } plan_t;

  // opening table, run with the reset configuration (mode 0, msb first,
  // one tick per half period); a 0xff byte is started, a 0x00 last byte is
  // offered all through it and only taken on the tick the first byte ends
  localparam dir_row_t DIRECTED [25] = '{
    '{'{1'b0, 8'h00, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00}},
    '{'{1'b1, 8'hFF, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00}},
    '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b0, '0},
    '{'{1'b1, 8'h00, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'hFF}},
    '{'{1'b0, 8'hFF, 1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b0, 8'hFF, 1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h00, 1'b0, 1'b1}, 1'b0, '0},
    '{'{1'b0, 8'hFF, 1'b1, 1'b0}, 1'b0, '0},
    '{'{1'b0, 8'h00, 1'b0, 1'b1}, 1'b0, '0}
  };

  // random phases: mode, lsb first, half period, sender idle %, stall %, ticks
  localparam plan_t RUN_PLAN [9] = '{
    '{2'd0, 1'b0, 16'd1,     7'd0,  7'd0,  12'd200},
    '{2'd1, 1'b1, 16'd2,     7'd67, 7'd0,  12'd200},
    '{2'd2, 1'b0, 16'd0,     7'd0,  7'd67, 12'd200},
    '{2'd3, 1'b1, 16'd3,     7'd14, 7'd14, 12'd200},
    '{2'd3, 1'b0, 16'hFFFF,  7'd0,  7'd0,  12'd150},
    '{2'd0, 1'b1, 16'd1,     7'd14, 7'd14, 12'd200},
    '{2'd2, 1'b1, 16'd2,     7'd67, 7'd0,  12'd150},
    '{2'd1, 1'b0, 16'd1,     7'd0,  7'd67, 12'd200},
    '{2'd3, 1'b0, 16'd1,     7'd0,  7'd0,  12'd200}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_BUS_MODE;
  logic [HALF_W-1:0]    cfg_data = '0;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  item_t                item_req = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_cnt = 0;
  int quiet_cycles = 0;

  // expected tick results, oldest first
  result_t due_q [$];

  // configuration as the engine should see it
  logic [1:0]        cfg_mode = 2'd0;
  logic              cfg_lsb = 1'b0;
  logic [HALF_W-1:0] cfg_half = 16'd1;

  // engine state of the behavioral copy
  phase_t            eng_phase = PH_IDLE;
  logic [HALF_W-1:0] tick_cnt = '0;
  logic [2:0]        bit_idx = '0;
  logic [7:0]        tx_sh = '0;
  logic [7:0]        rx_sh = '0;
  logic              last_pend = 1'b0;
  logic              sclk_lvl = 1'b0;
  logic              mosi_lvl = 1'b0;
  logic              cs_lvl = 1'b1;

  spi_master_byte_engine dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_req),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // half-period divider: true on the tick that closes the current half
  // (a zero setting counts as one)
  function automatic logic half_elapsed();
    logic [HALF_W:0] lim;
    lim = (cfg_half == '0) ? (HALF_W+1)'(1) : {1'b0, cfg_half};
    if ({1'b0, tick_cnt} + 1 >= lim) begin
      tick_cnt = '0;
      return 1'b1;
    end
    tick_cnt = tick_cnt + 1'b1;
    return 1'b0;
  endfunction

  // first half of a bit: mosi takes the selected bit, cpha 1 gives the
  // leading edge here
  function automatic void launch_bit();
    logic [2:0] sel;
    sel = cfg_lsb ? bit_idx : LAST_BIT - bit_idx;
    if (cfg_mode[0])
      sclk_lvl = ~cfg_mode[1];
    mosi_lvl = tx_sh[sel];
    eng_phase = PH_FIRST;
  endfunction

  function automatic void load_byte(input item_t req);
    tx_sh = req.tx_byte;
    last_pend = req.tx_last;
    bit_idx = '0;
    tick_cnt = '0;
  endfunction

  // one engine tick: line levels afterwards, take flag and finished byte
  function automatic result_t step_engine(input item_t req);
    result_t r;
    logic cpol;
    logic cpha;
    r = '0;
    cpol = cfg_mode[1];
    cpha = cfg_mode[0];
    case (eng_phase)
      PH_SETUP: begin
        if (half_elapsed())
          launch_bit();
      end
      PH_FIRST: begin
        if (half_elapsed()) begin
          sclk_lvl = cpha ? cpol : ~cpol;
          rx_sh = cfg_lsb ? {req.miso, rx_sh[7:1]} : {rx_sh[6:0], req.miso};
          eng_phase = PH_SECOND;
        end
      end
      PH_SECOND: begin
        if (half_elapsed()) begin
          if (!cpha)
            sclk_lvl = cpol;
          if (bit_idx == LAST_BIT) begin
            r.rx_valid = 1'b1;
            r.rx_byte = rx_sh;
            bit_idx = '0;
            if (last_pend) begin
              eng_phase = PH_HOLD;
            end else if (req.tx_valid) begin
              // next byte taken on the very tick the previous one ends
              r.tx_ready = 1'b1;
              load_byte(req);
              launch_bit();
            end else begin
              eng_phase = PH_WAIT;
            end
          end else begin
            bit_idx = bit_idx + 1'b1;
            launch_bit();
          end
        end
      end
      PH_WAIT: begin
        if (req.tx_valid) begin
          r.tx_ready = 1'b1;
          load_byte(req);
          launch_bit();
        end
      end
      PH_HOLD: begin
        if (half_elapsed()) begin
          cs_lvl = 1'b1;
          sclk_lvl = cpol;
          eng_phase = PH_IDLE;
        end
      end
      default: begin
        // idle: clock follows the current polarity, an offer opens a transfer
        sclk_lvl = cpol;
        cs_lvl = 1'b1;
        if (req.tx_valid) begin
          r.tx_ready = 1'b1;
          load_byte(req);
          cs_lvl = 1'b0;
          eng_phase = PH_SETUP;
        end else begin
          eng_phase = PH_IDLE;
        end
      end
    endcase
    r.sclk = sclk_lvl;
    r.mosi = mosi_lvl;
    r.cs_n = cs_lvl;
    return r;
  endfunction

  // present one tick request, hold it until taken, then queue its outcome;
  // a typed row queues the hand-written value instead of the computed one
  task automatic offer_tick(input item_t req, input logic typed,
                            input result_t typed_res, output result_t pred);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item_req <= req;
    do
      @(posedge clk);
    while (item_stall);
    pred = step_engine(req);
    due_q.push_back(typed ? typed_res : pred);
  endtask

  // receiver back-pressure
  always @(posedge clk)
    result_stall <= ($urandom_range(99) < recv_stall_pct);

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (due_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result %h at %0.1f ns", result, $realtime);
      end else begin
        want = due_q.pop_front();
        if (result.sclk !== want.sclk || result.mosi !== want.mosi ||
            result.cs_n !== want.cs_n || result.tx_ready !== want.tx_ready ||
            result.rx_valid !== want.rx_valid || result.rx_byte !== want.rx_byte) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch at %0.1f ns (sclk mosi cs_n ready rx_valid rx_byte)",
                     $realtime);
            $display("  expected %b %b %b %b %b %h, got %b %b %b %b %b %h",
                     want.sclk, want.mosi, want.cs_n, want.tx_ready,
                     want.rx_valid, want.rx_byte, result.sclk, result.mosi,
                     result.cs_n, result.tx_ready, result.rx_valid, result.rx_byte);
          end
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no handshake for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    item_t     req;
    result_t   got;
    int        left;
    int        gap;
    logic      holding;
    logic [7:0] hold_byte;
    logic      hold_last;

    left = 0;
    gap = 0;
    holding = 1'b0;
    hold_byte = '0;
    hold_last = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      offer_tick(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want, got);

    foreach (RUN_PLAN[p]) begin
      // drain, then reprogram all three registers back to back
      item_valid <= 1'b0;
      while (due_q.size() != 0)
        @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= CFG_BUS_MODE;
      cfg_data <= HALF_W'(RUN_PLAN[p].mode);
      @(posedge clk);
      cfg_mode = RUN_PLAN[p].mode;
      cfg_index <= CFG_LSB_FIRST;
      cfg_data <= HALF_W'(RUN_PLAN[p].lsb);
      @(posedge clk);
      cfg_lsb = RUN_PLAN[p].lsb;
      cfg_index <= CFG_HALF_PERIOD;
      cfg_data <= RUN_PLAN[p].half;
      @(posedge clk);
      cfg_half = RUN_PLAN[p].half;
      cfg_we <= 1'b0;
      send_idle_pct = RUN_PLAN[p].idle_pct;
      recv_stall_pct = RUN_PLAN[p].stall_pct;

      repeat (RUN_PLAN[p].items) begin
        // transactions of one to four bytes, a byte is held on the bus
        // until the engine takes it, with gaps between bytes and transfers
        if (!holding) begin
          if (left == 0) begin
            if (gap == 0) begin
              left = $urandom_range(4, 1);
              gap = $urandom_range(40);
            end else begin
              gap--;
            end
          end
          if (left != 0 && $urandom_range(99) < 70) begin
            holding = 1'b1;
            hold_byte = 8'($urandom);
            hold_last = (left == 1);
          end
        end
        req.miso = 1'($urandom);
        if (holding) begin
          req.tx_valid = 1'b1;
          req.tx_byte = hold_byte;
          req.tx_last = hold_last;
        end else begin
          // stray offers: ignored while busy, otherwise break the framing
          req.tx_valid = ($urandom_range(99) < 8);
          req.tx_byte = 8'($urandom);
          req.tx_last = 1'($urandom);
        end
        offer_tick(req, 1'b0, '0, got);
        if (holding && got.tx_ready) begin
          holding = 1'b0;
          left--;
        end
      end
    end

    item_valid <= 1'b0;
    while (due_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_cnt == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/spimbe_pkg.sv
hdl/spimbe_step.sv
hdl/spi_master_byte_engine.sv
tb/spi_master_byte_engine_test.sv
